// File: rtl/core/crrc_pkg.sv
// Package for the chunk residency record checker: lifecycle, action, status
// and invariant codes, the transfer payload structs and the record checks.
// Depends on nothing.
package crrc_pkg;

  localparam int NUM_CHUNKS = 256;
  localparam int GEN_BITS   = 64;
  localparam int IDX_BITS   = $clog2(NUM_CHUNKS);
  localparam logic [GEN_BITS-1:0] GEN_MAX = '1;

  typedef enum logic [3:0] {
    ST_HOST_ONLY  = 4'd0,
    ST_PREFETCH   = 4'd1,
    ST_MAPPING    = 4'd2,
    ST_H2D        = 4'd3,
    ST_CLEAN      = 4'd4,
    ST_DIRTY      = 4'd5,
    ST_WB_QUEUED  = 4'd6,
    ST_D2H        = 4'd7,
    ST_EVICTING   = 4'd8,
    ST_POISONED   = 4'd9
  } chunk_state_t;

  typedef enum logic [1:0] {
    ACT_TRANSITION = 2'd0,
    ACT_BEGIN_GEN  = 2'd1,
    ACT_COMPLETE   = 2'd2,
    ACT_QUERY      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_ILLEGAL   = 3'd1,
    STS_OVERFLOW  = 3'd2,
    STS_INVALID   = 3'd3,
    STS_COMPLETED = 3'd4,
    STS_STALE     = 3'd5,
    STS_FUTURE    = 3'd6
  } status_t;

  localparam logic [3:0] INV_NONE           = 4'd0;
  localparam logic [3:0] INV_BAD_KEY        = 4'd1;
  localparam logic [3:0] INV_AHEAD          = 4'd2;
  localparam logic [3:0] INV_EXTRA_FRAME    = 4'd3;
  localparam logic [3:0] INV_NO_FRAME       = 4'd4;
  localparam logic [3:0] INV_EXTRA_STAGING  = 4'd5;
  localparam logic [3:0] INV_NO_STAGING     = 4'd6;
  localparam logic [3:0] INV_PIN_HOST       = 4'd7;
  localparam logic [3:0] INV_PIN_EVICT      = 4'd8;
  localparam logic [3:0] INV_WS_HOST        = 4'd9;
  localparam logic [3:0] INV_WS_EVICT       = 4'd10;
  localparam logic [3:0] INV_EVICT_GEN      = 4'd11;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  record_sel;
    logic [3:0]  target_state;
    logic [63:0] generation;
    logic        key_valid;
    logic        pinned;
    logic        in_working_set;
    logic        frame_present;
    logic        staging_present;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] invariant_error;
    logic [3:0] chunk_state;
    logic       in_flight;
    logic       victim_eligible;
    logic       safe_to_unmap;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          state;
    logic [GEN_BITS-1:0] issued;
    logic [GEN_BITS-1:0] finished;
  } rec_t;

  function automatic logic legal_move(logic [3:0] from, logic [3:0] to);
    logic ok;
    ok = 1'b0;
    if (to == ST_POISONED) begin
      ok = 1'b1;
    end else begin
      case (from)
        ST_HOST_ONLY:  ok = (to == ST_PREFETCH) || (to == ST_MAPPING);
        ST_PREFETCH:   ok = (to == ST_HOST_ONLY) || (to == ST_MAPPING);
        ST_MAPPING:    ok = (to == ST_H2D) || (to == ST_CLEAN);
        ST_H2D:        ok = (to == ST_CLEAN);
        ST_CLEAN:      ok = (to == ST_DIRTY) || (to == ST_EVICTING);
        ST_DIRTY:      ok = (to == ST_WB_QUEUED);
        ST_WB_QUEUED:  ok = (to == ST_D2H);
        ST_D2H:        ok = (to == ST_CLEAN);
        ST_EVICTING:   ok = (to == ST_HOST_ONLY);
        default:       ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  function automatic logic [3:0] check_record(logic [3:0] s, logic [GEN_BITS-1:0] iss,
                                              logic [GEN_BITS-1:0] fin, logic key,
                                              logic pin, logic ws, logic frame,
                                              logic stg);
    logic       hostish;
    logic       evict;
    logic       holds;
    logic       needs;
    logic       bars;
    logic [3:0] inv;
    hostish = (s == ST_HOST_ONLY) || (s == ST_PREFETCH);
    evict   = (s == ST_EVICTING);
    holds   = (s >= ST_MAPPING) && (s <= ST_EVICTING);
    needs   = (s == ST_H2D) || (s == ST_D2H);
    bars    = hostish || (s == ST_CLEAN) || (s == ST_DIRTY) || (s == ST_WB_QUEUED) || evict;
    if (!key)                     inv = INV_BAD_KEY;
    else if (fin > iss)           inv = INV_AHEAD;
    else if (s == ST_POISONED)    inv = INV_NONE;
    else if (holds && !frame)     inv = INV_NO_FRAME;
    else if (!holds && frame)     inv = INV_EXTRA_FRAME;
    else if (needs && !stg)       inv = INV_NO_STAGING;
    else if (bars && stg)         inv = INV_EXTRA_STAGING;
    else if (hostish && pin)      inv = INV_PIN_HOST;
    else if (evict && pin)        inv = INV_PIN_EVICT;
    else if (hostish && ws)       inv = INV_WS_HOST;
    else if (evict && ws)         inv = INV_WS_EVICT;
    else if (evict && fin != iss) inv = INV_EVICT_GEN;
    else                          inv = INV_NONE;
    return inv;
  endfunction

endpackage

// File: rtl/core/chunk_residency_record_checker_top.sv
// Top level of the chunk residency record checker: record memory, per-entry
// valid bits, write-back bypass, action logic and result register.
// Depends on crrc_pkg.
//
//  channel | ports                           | direction | payload
//  --------+---------------------------------+-----------+-------------------
//  input   | in_valid, in_ready, in_data     | in        | crrc_pkg::in_item_t
//  result  | out_valid, out_ready, out_data  | out       | crrc_pkg::out_item_t
//
// One item per cycle while the result side is not stalled; an input transfer loads the
// action stage, which then loads the result register that holds it until it transfers.
// Reset clears the per-entry valid bits, so every record reads as the host state
// with zero generations at once; no clearing pass.
// A stalled result holds the action stage; input is taken while the action stage
// is empty or advances in the same cycle.
module chunk_residency_record_checker_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crrc_pkg::out_item_t out_data
);

  crrc_pkg::rec_t                   mem [crrc_pkg::NUM_CHUNKS];
  logic [crrc_pkg::NUM_CHUNKS-1:0]  vld_r;
  crrc_pkg::rec_t                   rd_rec_r;
  crrc_pkg::rec_t                   byp_rec_r;
  logic                             byp_r;
  crrc_pkg::in_item_t               s1_r;
  logic                             s1_valid_r;
  crrc_pkg::out_item_t              out_r;
  logic                             out_valid_r;

  logic                             in_fire;
  logic                             s1_go;
  logic [crrc_pkg::IDX_BITS-1:0]    in_idx;
  logic [crrc_pkg::IDX_BITS-1:0]    s1_idx;
  crrc_pkg::rec_t                   rec_cur;
  crrc_pkg::rec_t                   rec_nxt;
  logic [2:0]                       status_c;
  logic [3:0]                       inv_c;
  logic [63:0]                      iss64;
  logic [63:0]                      fin64;
  logic                             gens_done;
  logic                             pin;
  logic                             ws;
  logic                             stg;
  crrc_pkg::out_item_t              out_nxt;

  assign in_idx   = in_data.record_sel[crrc_pkg::IDX_BITS-1:0];
  assign s1_idx   = s1_r.record_sel[crrc_pkg::IDX_BITS-1:0];
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (byp_r) begin
      rec_cur = byp_rec_r;
    end else if (vld_r[s1_idx]) begin
      rec_cur = rd_rec_r;
    end else begin
      rec_cur = '0;
    end
  end

  always_comb begin
    rec_nxt  = rec_cur;
    status_c = crrc_pkg::STS_OK;
    iss64    = 64'(rec_cur.issued);
    fin64    = 64'(rec_cur.finished);
    case (s1_r.action)
      crrc_pkg::ACT_TRANSITION: begin
        if (crrc_pkg::legal_move(rec_cur.state, s1_r.target_state)) begin
          rec_nxt.state = s1_r.target_state;
        end else begin
          status_c = crrc_pkg::STS_ILLEGAL;
        end
      end
      crrc_pkg::ACT_BEGIN_GEN: begin
        if (rec_cur.issued == crrc_pkg::GEN_MAX) begin
          status_c = crrc_pkg::STS_OVERFLOW;
        end else begin
          rec_nxt.issued = rec_cur.issued + 1'b1;
        end
      end
      crrc_pkg::ACT_COMPLETE: begin
        if (s1_r.generation == 64'd0) begin
          status_c = crrc_pkg::STS_INVALID;
        end else if (s1_r.generation < iss64) begin
          status_c = (s1_r.generation <= fin64) ? crrc_pkg::STS_COMPLETED
                                                : crrc_pkg::STS_STALE;
        end else if (s1_r.generation > iss64) begin
          status_c = crrc_pkg::STS_FUTURE;
        end else if (s1_r.generation <= fin64) begin
          status_c = crrc_pkg::STS_COMPLETED;
        end else begin
          rec_nxt.finished = s1_r.generation[crrc_pkg::GEN_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign pin       = s1_r.pinned;
  assign ws        = s1_r.in_working_set;
  assign stg       = s1_r.staging_present;
  assign gens_done = (rec_nxt.finished == rec_nxt.issued);
  assign inv_c     = crrc_pkg::check_record(rec_nxt.state, rec_nxt.issued, rec_nxt.finished,
                                            s1_r.key_valid, pin, ws, s1_r.frame_present, stg);

  always_comb begin
    out_nxt.status          = status_c;
    out_nxt.invariant_error = inv_c;
    out_nxt.chunk_state     = rec_nxt.state;
    out_nxt.in_flight       = (rec_nxt.state == crrc_pkg::ST_MAPPING) ||
                              (rec_nxt.state == crrc_pkg::ST_H2D) ||
                              (rec_nxt.state == crrc_pkg::ST_D2H) || !gens_done;
    out_nxt.victim_eligible = ((rec_nxt.state == crrc_pkg::ST_CLEAN) ||
                               (rec_nxt.state == crrc_pkg::ST_DIRTY)) &&
                              !pin && !ws && !stg && gens_done &&
                              (inv_c == crrc_pkg::INV_NONE);
    out_nxt.safe_to_unmap   = (rec_nxt.state == crrc_pkg::ST_EVICTING) && !pin && !ws &&
                              s1_r.frame_present && !stg && gens_done &&
                              (inv_c == crrc_pkg::INV_NONE);
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem[s1_idx] <= rec_nxt;
    end
    if (in_fire) begin
      rd_rec_r  <= mem[in_idx];
      byp_rec_r <= rec_nxt;
      s1_r      <= in_data;
    end
    if (s1_go) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      byp_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        vld_r[s1_idx] <= 1'b1;
      end
      if (in_fire) begin
        byp_r <= s1_go && (s1_idx == in_idx);
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a held result");

  a_bypass_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(byp_r) |-> $past(s1_go))
    else $error("bypass set without a write-back");

  a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.chunk_state <= crrc_pkg::ST_POISONED))
    else $error("result state out of range");

  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> vld_r[$past(s1_idx)])
    else $error("entry not marked valid after write-back");

endmodule

// File: dv/residency_result_checker.sv
// Result checker for the chunk residency record checker: tracks its own copy of
// the record table, predicts one result per input transfer and compares results.
// Depends on crrc_pkg.
module residency_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  crrc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  crrc_pkg::out_item_t out_data,
  output int                  mismatch_count,
  output int                  outstanding,
  output int                  results_checked,
  output logic [7:0]          statuses_seen,
  output logic [15:0]         faults_seen
);

  crrc_pkg::chunk_state_t        life_state [crrc_pkg::NUM_CHUNKS];
  logic [crrc_pkg::GEN_BITS-1:0] issued_gen [crrc_pkg::NUM_CHUNKS];
  logic [crrc_pkg::GEN_BITS-1:0] done_gen   [crrc_pkg::NUM_CHUNKS];
  crrc_pkg::out_item_t           predicted_results [$];

  function automatic logic [15:0] successor_mask(crrc_pkg::chunk_state_t from);
    case (from)
      crrc_pkg::ST_HOST_ONLY:
        return (16'h1 << crrc_pkg::ST_PREFETCH) | (16'h1 << crrc_pkg::ST_MAPPING);
      crrc_pkg::ST_PREFETCH:
        return (16'h1 << crrc_pkg::ST_HOST_ONLY) | (16'h1 << crrc_pkg::ST_MAPPING);
      crrc_pkg::ST_MAPPING:
        return (16'h1 << crrc_pkg::ST_H2D) | (16'h1 << crrc_pkg::ST_CLEAN);
      crrc_pkg::ST_H2D:       return 16'h1 << crrc_pkg::ST_CLEAN;
      crrc_pkg::ST_CLEAN:
        return (16'h1 << crrc_pkg::ST_DIRTY) | (16'h1 << crrc_pkg::ST_EVICTING);
      crrc_pkg::ST_DIRTY:     return 16'h1 << crrc_pkg::ST_WB_QUEUED;
      crrc_pkg::ST_WB_QUEUED: return 16'h1 << crrc_pkg::ST_D2H;
      crrc_pkg::ST_D2H:       return 16'h1 << crrc_pkg::ST_CLEAN;
      crrc_pkg::ST_EVICTING:  return 16'h1 << crrc_pkg::ST_HOST_ONLY;
      default:                return 16'h0;
    endcase
  endfunction

  function automatic logic [3:0] first_fault(crrc_pkg::chunk_state_t s,
                                             logic [crrc_pkg::GEN_BITS-1:0] iss,
                                             logic [crrc_pkg::GEN_BITS-1:0] fin,
                                             crrc_pkg::in_item_t it);
    logic host_side;
    logic evict;
    logic framed;
    logic staged;
    logic unstaged;
    host_side = s inside {crrc_pkg::ST_HOST_ONLY, crrc_pkg::ST_PREFETCH};
    evict     = (s == crrc_pkg::ST_EVICTING);
    framed    = s inside {crrc_pkg::ST_MAPPING, crrc_pkg::ST_H2D, crrc_pkg::ST_CLEAN,
                          crrc_pkg::ST_DIRTY, crrc_pkg::ST_WB_QUEUED, crrc_pkg::ST_D2H,
                          crrc_pkg::ST_EVICTING};
    staged    = s inside {crrc_pkg::ST_H2D, crrc_pkg::ST_D2H};
    unstaged  = !staged && (s != crrc_pkg::ST_MAPPING) && (s != crrc_pkg::ST_POISONED);
    if (!it.key_valid) return crrc_pkg::INV_BAD_KEY;
    if (fin > iss) return crrc_pkg::INV_AHEAD;
    if (s == crrc_pkg::ST_POISONED) return crrc_pkg::INV_NONE;
    if (framed != it.frame_present) begin
      return framed ? crrc_pkg::INV_NO_FRAME : crrc_pkg::INV_EXTRA_FRAME;
    end
    if (staged && !it.staging_present) return crrc_pkg::INV_NO_STAGING;
    if (unstaged && it.staging_present) return crrc_pkg::INV_EXTRA_STAGING;
    if (it.pinned && host_side) return crrc_pkg::INV_PIN_HOST;
    if (it.pinned && evict) return crrc_pkg::INV_PIN_EVICT;
    if (it.in_working_set && host_side) return crrc_pkg::INV_WS_HOST;
    if (it.in_working_set && evict) return crrc_pkg::INV_WS_EVICT;
    if (evict && (fin != iss)) return crrc_pkg::INV_EVICT_GEN;
    return crrc_pkg::INV_NONE;
  endfunction

  function automatic crrc_pkg::out_item_t apply_record_action(crrc_pkg::in_item_t it);
    int                            slot;
    crrc_pkg::status_t             st;
    crrc_pkg::chunk_state_t        s;
    logic [crrc_pkg::GEN_BITS-1:0] iss;
    logic [crrc_pkg::GEN_BITS-1:0] fin;
    logic [3:0]                    fault;
    logic                          settled;
    logic [15:0]                   succ;
    crrc_pkg::out_item_t           r;
    slot = it.record_sel % crrc_pkg::NUM_CHUNKS;
    st   = crrc_pkg::STS_OK;
    case (crrc_pkg::action_t'(it.action))
      crrc_pkg::ACT_TRANSITION: begin
        succ = successor_mask(life_state[slot]);
        if ((it.target_state == crrc_pkg::ST_POISONED) || succ[it.target_state]) begin
          life_state[slot] = crrc_pkg::chunk_state_t'(it.target_state);
        end else begin
          st = crrc_pkg::STS_ILLEGAL;
        end
      end
      crrc_pkg::ACT_BEGIN_GEN: begin
        if (issued_gen[slot] >= crrc_pkg::GEN_MAX) begin
          st = crrc_pkg::STS_OVERFLOW;
        end else begin
          issued_gen[slot] = issued_gen[slot] + 1'b1;
        end
      end
      crrc_pkg::ACT_COMPLETE: begin
        iss = issued_gen[slot];
        fin = done_gen[slot];
        if (it.generation == '0) begin
          st = crrc_pkg::STS_INVALID;
        end else if (it.generation < iss) begin
          st = (it.generation <= fin) ? crrc_pkg::STS_COMPLETED : crrc_pkg::STS_STALE;
        end else if (it.generation > iss) begin
          st = crrc_pkg::STS_FUTURE;
        end else if (it.generation <= fin) begin
          st = crrc_pkg::STS_COMPLETED;
        end else begin
          done_gen[slot] = it.generation;
        end
      end
      default: ;
    endcase
    s       = life_state[slot];
    iss     = issued_gen[slot];
    fin     = done_gen[slot];
    fault   = first_fault(s, iss, fin, it);
    settled = (fin == iss);
    r.status          = st;
    r.invariant_error = fault;
    r.chunk_state     = s;
    r.in_flight       = (s inside {crrc_pkg::ST_MAPPING, crrc_pkg::ST_H2D, crrc_pkg::ST_D2H}) ||
                        !settled;
    r.victim_eligible = (s inside {crrc_pkg::ST_CLEAN, crrc_pkg::ST_DIRTY}) && !it.pinned &&
                        !it.in_working_set && !it.staging_present && settled &&
                        (fault == crrc_pkg::INV_NONE);
    r.safe_to_unmap   = (s == crrc_pkg::ST_EVICTING) && !it.pinned && !it.in_working_set &&
                        it.frame_present && !it.staging_present && settled &&
                        (fault == crrc_pkg::INV_NONE);
    return r;
  endfunction

  always @(posedge clk) begin
    crrc_pkg::out_item_t want;
    logic                bad;
    if (!rst_n) begin
      for (int i = 0; i < crrc_pkg::NUM_CHUNKS; i++) begin
        life_state[i] = crrc_pkg::ST_HOST_ONLY;
        issued_gen[i] = '0;
        done_gen[i]   = '0;
      end
      predicted_results.delete();
      mismatch_count  = 0;
      results_checked = 0;
      statuses_seen   = '0;
      faults_seen     = '0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        statuses_seen[out_data.status]        = 1'b1;
        faults_seen[out_data.invariant_error] = 1'b1;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] result transfer with nothing predicted: status %0d inv %0d state %0d",
                     $realtime, out_data.status, out_data.invariant_error,
                     out_data.chunk_state);
          end
        end else begin
          want = predicted_results.pop_front();
          bad  = (out_data.status !== want.status) ||
                 (out_data.invariant_error !== want.invariant_error) ||
                 (out_data.chunk_state !== want.chunk_state) ||
                 (out_data.in_flight !== want.in_flight) ||
                 (out_data.victim_eligible !== want.victim_eligible) ||
                 (out_data.safe_to_unmap !== want.safe_to_unmap);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] result %0d: expected sts %0d inv %0d st %0d fl/vi/un %b%b%b",
                       $realtime, results_checked, want.status, want.invariant_error,
                       want.chunk_state, want.in_flight, want.victim_eligible,
                       want.safe_to_unmap);
              $display("[%0t] result %0d:   actual sts %0d inv %0d st %0d fl/vi/un %b%b%b",
                       $realtime, results_checked, out_data.status, out_data.invariant_error,
                       out_data.chunk_state, out_data.in_flight, out_data.victim_eligible,
                       out_data.safe_to_unmap);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted_results = {predicted_results, apply_record_action(in_data)};
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the chunk residency record checker testbench: clock, reset, directed and
// random operation streams, result-side backpressure, watchdog and verdict.
// Depends on crrc_pkg, chunk_residency_record_checker_top and residency_result_checker.
module testbench;

  localparam int RANDOM_OPS  = 1200;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;
  localparam int POOL        = 16;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  crrc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  crrc_pkg::out_item_t out_data;
  logic                calm      = 1'b0;

  int          mismatch_count;
  int          outstanding;
  int          results_checked;
  logic [7:0]  statuses_seen;
  logic [15:0] faults_seen;
  int          ops_sent;

  crrc_pkg::chunk_state_t        walk_state  [POOL];
  logic [crrc_pkg::GEN_BITS-1:0] walk_issued [POOL];
  logic [crrc_pkg::GEN_BITS-1:0] walk_done   [POOL];

  chunk_residency_record_checker_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  residency_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .statuses_seen   (statuses_seen),
    .faults_seen     (faults_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 14);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("FAIL chunk_residency_record_checker_top");
    $finish;
  end

  // enter and leave at a falling edge
  task automatic send_op(input crrc_pkg::in_item_t op);
    int gap;
    gap = 0;
    while (!calm && ($urandom_range(99) < 14)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
    @(negedge clk);
  endtask

  // flags: key_valid, pinned, in_working_set, frame_present, staging_present
  task automatic push_op(input crrc_pkg::action_t act, input logic [7:0] idx,
                         input logic [3:0] tgt, input logic [63:0] gen,
                         input logic [4:0] flags);
    crrc_pkg::in_item_t op;
    op.action          = act;
    op.record_sel      = idx;
    op.target_state    = tgt;
    op.generation      = gen;
    op.key_valid       = flags[4];
    op.pinned          = flags[3];
    op.in_working_set  = flags[2];
    op.frame_present   = flags[1];
    op.staging_present = flags[0];
    send_op(op);
  endtask

  function automatic crrc_pkg::chunk_state_t next_hop(crrc_pkg::chunk_state_t s);
    logic coin;
    coin = 1'($urandom_range(1));
    case (s)
      crrc_pkg::ST_HOST_ONLY: return coin ? crrc_pkg::ST_PREFETCH : crrc_pkg::ST_MAPPING;
      crrc_pkg::ST_PREFETCH:  return coin ? crrc_pkg::ST_HOST_ONLY : crrc_pkg::ST_MAPPING;
      crrc_pkg::ST_MAPPING:   return coin ? crrc_pkg::ST_H2D : crrc_pkg::ST_CLEAN;
      crrc_pkg::ST_H2D:       return crrc_pkg::ST_CLEAN;
      crrc_pkg::ST_CLEAN:     return coin ? crrc_pkg::ST_DIRTY : crrc_pkg::ST_EVICTING;
      crrc_pkg::ST_DIRTY:     return crrc_pkg::ST_WB_QUEUED;
      crrc_pkg::ST_WB_QUEUED: return crrc_pkg::ST_D2H;
      crrc_pkg::ST_D2H:       return crrc_pkg::ST_CLEAN;
      crrc_pkg::ST_EVICTING:  return crrc_pkg::ST_HOST_ONLY;
      default:                return crrc_pkg::ST_POISONED;
    endcase
  endfunction

  initial begin
    crrc_pkg::in_item_t     op;
    crrc_pkg::chunk_state_t after;
    int                     slot;
    int                     pick;
    ops_sent = 0;
    for (int i = 0; i < POOL; i++) begin
      walk_state[i]  = crrc_pkg::ST_HOST_ONLY;
      walk_issued[i] = '0;
      walk_done[i]   = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_op(crrc_pkg::ACT_QUERY,      8'd0,   4'd0,                   64'd0, 5'b00000);
    push_op(crrc_pkg::ACT_QUERY,      8'd255, 4'hF,                   '1,    5'b11111);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, 4'hF,                   64'd0, 5'b10000);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_MAPPING,   64'd0, 5'b10010);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_H2D,       64'd0, 5'b10011);
    push_op(crrc_pkg::ACT_COMPLETE,   8'd200, 4'd0,                   64'd0, 5'b10011);
    push_op(crrc_pkg::ACT_BEGIN_GEN,  8'd200, 4'd0,                   64'd0, 5'b10011);
    push_op(crrc_pkg::ACT_COMPLETE,   8'd200, 4'd0,                   '1,    5'b10011);
    push_op(crrc_pkg::ACT_BEGIN_GEN,  8'd200, 4'd0,                   64'd0, 5'b10011);
    push_op(crrc_pkg::ACT_COMPLETE,   8'd200, 4'd0,                   64'd1, 5'b10011);
    push_op(crrc_pkg::ACT_COMPLETE,   8'd200, 4'd0,                   64'd2, 5'b10011);
    push_op(crrc_pkg::ACT_COMPLETE,   8'd200, 4'd0,                   64'd2, 5'b10011);
    push_op(crrc_pkg::ACT_COMPLETE,   8'd200, 4'd0,                   64'd1, 5'b10011);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_CLEAN,     64'd0, 5'b10010);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_DIRTY,     64'd0, 5'b11010);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_WB_QUEUED, 64'd0, 5'b10110);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_D2H,       64'd0, 5'b10011);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_CLEAN,     64'd0, 5'b10010);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_EVICTING,  64'd0, 5'b10010);
    push_op(crrc_pkg::ACT_BEGIN_GEN,  8'd200, 4'd0,                   64'd0, 5'b10010);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd200, crrc_pkg::ST_HOST_ONLY, 64'd0, 5'b10000);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd201, crrc_pkg::ST_POISONED,  64'd0, 5'b10101);
    push_op(crrc_pkg::ACT_TRANSITION, 8'd201, crrc_pkg::ST_HOST_ONLY, 64'd0, 5'b10000);
    push_op(crrc_pkg::ACT_QUERY,      8'd201, 4'd0,                   64'd0, 5'b01100);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= 500) && (n < 800);
      op.generation   = {$urandom(), $urandom()};
      op.target_state = 4'($urandom_range(15));
      if ($urandom_range(3) != 0) begin
        slot  = $urandom_range(POOL - 1);
        pick  = $urandom_range(99);
        after = walk_state[slot];
        op.record_sel = 8'(slot);
        if (pick < 45) begin
          op.action       = crrc_pkg::ACT_TRANSITION;
          after           = next_hop(walk_state[slot]);
          op.target_state = after;
        end else if (pick < 65) begin
          op.action = crrc_pkg::ACT_BEGIN_GEN;
        end else if (pick < 90) begin
          op.action = crrc_pkg::ACT_COMPLETE;
          case ($urandom_range(9))
            6:       op.generation = walk_issued[slot] - 1'b1;
            7:       op.generation = walk_done[slot];
            8:       op.generation = walk_issued[slot] + 1'b1;
            9:       op.generation = '0;
            default: op.generation = walk_issued[slot];
          endcase
        end else begin
          op.action = crrc_pkg::ACT_QUERY;
        end
        op.key_valid       = ($urandom_range(49) != 0);
        op.pinned          = ($urandom_range(9) == 0);
        op.in_working_set  = ($urandom_range(9) == 0);
        op.frame_present   = ((after >= crrc_pkg::ST_MAPPING) &&
                              (after <= crrc_pkg::ST_EVICTING)) ^
                             ($urandom_range(19) == 0);
        op.staging_present = ((after == crrc_pkg::ST_H2D) || (after == crrc_pkg::ST_D2H)) ^
                             ($urandom_range(19) == 0);
        send_op(op);
        walk_state[slot] = after;
        if (op.action == crrc_pkg::ACT_BEGIN_GEN) begin
          walk_issued[slot] = walk_issued[slot] + 1'b1;
        end else if ((op.action == crrc_pkg::ACT_COMPLETE) && (op.generation != '0) &&
                     (op.generation == walk_issued[slot]) &&
                     (op.generation > walk_done[slot])) begin
          walk_done[slot] = op.generation;
        end
      end else begin
        op.action          = 2'($urandom_range(3));
        op.record_sel      = 8'($urandom_range(255, POOL));
        op.key_valid       = 1'($urandom_range(1));
        op.pinned          = 1'($urandom_range(1));
        op.in_working_set  = 1'($urandom_range(1));
        op.frame_present   = 1'($urandom_range(1));
        op.staging_present = 1'($urandom_range(1));
        send_op(op);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d operations, checked %0d results, %0d mismatches",
             ops_sent, results_checked, mismatch_count);
    $display("status codes seen %b, invariant codes seen %b", statuses_seen, faults_seen);
    if (mismatch_count == 0) begin
      $display("PASS chunk_residency_record_checker_top");
    end else begin
      $display("FAIL chunk_residency_record_checker_top");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/crrc_pkg.sv
rtl/core/chunk_residency_record_checker_top.sv
dv/residency_result_checker.sv
dv/testbench.sv
